[rtl/core/convex_hull_graham_scan_core_macros.svh]
// Assertion macros shared by the convex hull checker.
`ifndef CONVEX_HULL_GRAHAM_SCAN_CORE_MACROS_SVH
`define CONVEX_HULL_GRAHAM_SCAN_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CHGS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CHGS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/chgs_pkg.sv]
// Package with the shared types and constants of the convex hull core.
package chgs_pkg;

  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_COORD_BITS = 16;
  localparam int HULL_SIZE_BITS = 7;

  typedef enum logic [5:0] {
    ST_LOAD,
    ST_PV_RD,
    ST_PV_FIRST,
    ST_PV_SCAN,
    ST_SI_FILL,
    ST_SO_NEXT,
    ST_SO_KEY,
    ST_SO_KEYPT,
    ST_SO_CHK,
    ST_SO_PREV,
    ST_SO_PREVPT,
    ST_SO_GO,
    ST_SO_WAIT,
    ST_SO_PUT,
    ST_SC_NEXT,
    ST_SC_T,
    ST_SC_TPT,
    ST_SC_CHK,
    ST_SC_R2,
    ST_SC_R1,
    ST_SC_R0,
    ST_SC_GO,
    ST_SC_WAIT,
    ST_SC_PUSH,
    ST_CL_RD,
    ST_CL_PT,
    ST_CL_LD,
    ST_DU_RD,
    ST_DU_PT,
    ST_DU_CMP,
    ST_EM_RD,
    ST_EM_PT,
    ST_EM_OUT
  } state_t;

  typedef struct packed {
    logic pt_we;
    logic pt_re;
    logic ord_we;
    logic ord_re;
    logic stk_we;
    logic stk_re;
    logic ld_a;
    logic ld_b;
    logic ld_c;
    logic ar_go;
    logic out_ld;
    logic out_last;
    logic out_ovf;
  } cmd_t;

  typedef struct packed {
    logic piv_less;
    logic ar_done;
    logic cross_pos;
    logic cross_zero;
    logic closer;
    logic same_c;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/chgs_dpath.sv]
// Datapath: point, order and stack memories, operand registers, cross product unit, output register.
module chgs_dpath #(
  parameter int MAX_POINTS = chgs_pkg::DEF_MAX_POINTS,
  parameter int COORD_BITS = chgs_pkg::DEF_COORD_BITS,
  parameter int IW         = $clog2(MAX_POINTS),
  parameter int OTW        = ((2 * COORD_BITS + chgs_pkg::HULL_SIZE_BITS + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  chgs_pkg::cmd_t                      cmd,
  output chgs_pkg::sts_t                      sts,
  input  logic [IW-1:0]                       pt_addr,
  input  logic signed [COORD_BITS-1:0]        wr_x,
  input  logic signed [COORD_BITS-1:0]        wr_y,
  input  logic [IW-1:0]                       ord_addr,
  input  logic [IW-1:0]                       ord_wdata,
  output logic [IW-1:0]                       ord_rdata,
  input  logic [IW-1:0]                       stk_addr,
  input  logic [IW-1:0]                       stk_wdata,
  output logic [IW-1:0]                       stk_rdata,
  input  logic [chgs_pkg::HULL_SIZE_BITS-1:0] hull_size,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [OTW-1:0]                      out_tdata,
  output logic                                out_tlast,
  output logic                                out_tuser
);
  import chgs_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int PW = 2 * CB + 4;
  localparam int PADW = OTW - 2 * CB - HULL_SIZE_BITS;

  logic [2*CB-1:0] pt_mem [MAX_POINTS];
  logic [IW-1:0]   ord_mem [MAX_POINTS];
  logic [IW-1:0]   stk_mem [MAX_POINTS];

  logic [2*CB-1:0] pt_rd_r;
  logic [IW-1:0]   ord_rd_r;
  logic [IW-1:0]   stk_rd_r;
  logic signed [CB-1:0] rd_x, rd_y;

  logic signed [CB-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic signed [CB:0]   d1x_r, d1y_r, d2x_r, d2y_r;
  logic signed [2*CB+1:0] p_m1, p_m2, p_s1, p_s2, p_t1, p_t2;
  logic signed [PW-1:0] m1_r, m2_r, s1_r, s2_r, t1_r, t2_r;
  logic signed [PW-1:0] cross_r, da_r, db_r;
  logic ar_v1_r, ar_v2_r, ar_v3_r;

  logic signed [CB-1:0] ox_r, oy_r;
  logic [HULL_SIZE_BITS-1:0] osz_r;
  logic olast_r, oovf_r, ovalid_r;

  always_ff @(posedge clk) begin
    if (cmd.pt_we) begin
      pt_mem[pt_addr] <= {wr_y, wr_x};
    end
    if (cmd.pt_re) begin
      pt_rd_r <= pt_mem[pt_addr];
    end
    if (cmd.ord_we) begin
      ord_mem[ord_addr] <= ord_wdata;
    end
    if (cmd.ord_re) begin
      ord_rd_r <= ord_mem[ord_addr];
    end
    if (cmd.stk_we) begin
      stk_mem[stk_addr] <= stk_wdata;
    end
    if (cmd.stk_re) begin
      stk_rd_r <= stk_mem[stk_addr];
    end
  end

  assign rd_x = pt_rd_r[CB-1:0];
  assign rd_y = pt_rd_r[2*CB-1:CB];
  assign ord_rdata = ord_rd_r;
  assign stk_rdata = stk_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_a) begin
      ax_r <= rd_x;
      ay_r <= rd_y;
    end
    if (cmd.ld_b) begin
      bx_r <= rd_x;
      by_r <= rd_y;
    end
    if (cmd.ld_c) begin
      cx_r <= rd_x;
      cy_r <= rd_y;
    end
  end

  // Three-stage cross product and squared distance pipeline around point A.
  assign p_m1 = d1x_r * d2y_r;
  assign p_m2 = d1y_r * d2x_r;
  assign p_s1 = d1x_r * d1x_r;
  assign p_s2 = d1y_r * d1y_r;
  assign p_t1 = d2x_r * d2x_r;
  assign p_t2 = d2y_r * d2y_r;

  always_ff @(posedge clk) begin
    d1x_r   <= (CB+1)'(bx_r) - (CB+1)'(ax_r);
    d1y_r   <= (CB+1)'(by_r) - (CB+1)'(ay_r);
    d2x_r   <= (CB+1)'(cx_r) - (CB+1)'(ax_r);
    d2y_r   <= (CB+1)'(cy_r) - (CB+1)'(ay_r);
    m1_r    <= PW'(p_m1);
    m2_r    <= PW'(p_m2);
    s1_r    <= PW'(p_s1);
    s2_r    <= PW'(p_s2);
    t1_r    <= PW'(p_t1);
    t2_r    <= PW'(p_t2);
    cross_r <= m1_r - m2_r;
    da_r    <= s1_r + s2_r;
    db_r    <= t1_r + t2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ar_v1_r <= 1'b0;
      ar_v2_r <= 1'b0;
      ar_v3_r <= 1'b0;
    end else begin
      ar_v1_r <= cmd.ar_go;
      ar_v2_r <= ar_v1_r;
      ar_v3_r <= ar_v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      ox_r    <= rd_x;
      oy_r    <= rd_y;
      osz_r   <= hull_size;
      olast_r <= cmd.out_last;
      oovf_r  <= cmd.out_ovf;
    end
  end

  always_comb begin
    sts.piv_less   = (rd_x < ax_r) || ((rd_x == ax_r) && (rd_y < ay_r));
    sts.ar_done    = ar_v3_r;
    sts.cross_pos  = cross_r > PW'(0);
    sts.cross_zero = cross_r == PW'(0);
    sts.closer     = da_r < db_r;
    sts.same_c     = (rd_x == cx_r) && (rd_y == cy_r);
    sts.out_free   = !ovalid_r || out_tready;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {{PADW{1'b0}}, osz_r, oy_r, ox_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = oovf_r;

endmodule

[rtl/core/chgs_ctrl.sv]
// Controller: sequences loading, pivot search, insertion sort, Graham scan and emission.
module chgs_ctrl #(
  parameter int MAX_POINTS = chgs_pkg::DEF_MAX_POINTS,
  parameter int IW         = $clog2(MAX_POINTS),
  parameter int CW         = $clog2(MAX_POINTS + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic                                in_tlast,
  output chgs_pkg::cmd_t                      cmd,
  input  chgs_pkg::sts_t                      sts,
  output logic [IW-1:0]                       pt_addr,
  output logic [IW-1:0]                       ord_addr,
  output logic [IW-1:0]                       ord_wdata,
  input  logic [IW-1:0]                       ord_rdata,
  output logic [IW-1:0]                       stk_addr,
  output logic [IW-1:0]                       stk_wdata,
  input  logic [IW-1:0]                       stk_rdata,
  output logic [chgs_pkg::HULL_SIZE_BITS-1:0] hull_size
);
  import chgs_pkg::*;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] sp_r, sp_nxt;
  logic [IW-1:0] key_r, key_nxt;
  logic [IW-1:0] prev_r, prev_nxt;
  logic [IW-1:0] t_r, t_nxt;
  logic drop_r, drop_nxt;
  logic close_r, close_nxt;

  logic in_acc, has_room, i_at_end, i_at_last, key_first, pop_limit_ok;
  logic [CW-1:0] i_p1, j_m1, sp_m1, sp_m2;

  assign in_acc    = in_tvalid && (state_r == ST_LOAD);
  assign has_room  = cnt_r < CW'(MAX_POINTS);
  assign i_p1      = i_r + CW'(1);
  assign j_m1      = j_r - CW'(1);
  assign sp_m1     = sp_r - CW'(1);
  assign sp_m2     = sp_r - CW'(2);
  assign i_at_end  = i_r == cnt_r;
  assign i_at_last = i_p1 == cnt_r;
  // Sort order: strict left turn first, closer point first when collinear.
  assign key_first = sts.cross_pos || (sts.cross_zero && sts.closer);
  // The closing pass keeps at least two points on the stack.
  assign pop_limit_ok = close_r ? (sp_r > CW'(2)) : (sp_r > CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      sp_r    <= '0;
      i_r     <= '0;
      j_r     <= '0;
      close_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      sp_r    <= sp_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      close_r <= close_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    prev_r <= prev_nxt;
    t_r    <= t_nxt;
  end

  // Next state and loop counters.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    drop_nxt  = drop_r;
    sp_nxt    = sp_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    close_nxt = close_r;
    key_nxt   = key_r;
    prev_nxt  = prev_r;
    t_nxt     = t_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            state_nxt = ST_PV_RD;
          end
        end
      end
      ST_PV_RD: state_nxt = ST_PV_FIRST;
      ST_PV_FIRST: begin
        if (cnt_r == CW'(1)) begin
          i_nxt     = '0;
          state_nxt = ST_SI_FILL;
        end else begin
          i_nxt     = CW'(1);
          state_nxt = ST_PV_SCAN;
        end
      end
      ST_PV_SCAN: begin
        if (i_at_last) begin
          i_nxt     = '0;
          state_nxt = ST_SI_FILL;
        end else begin
          i_nxt = i_p1;
        end
      end
      ST_SI_FILL: begin
        if (i_at_last) begin
          i_nxt     = CW'(1);
          state_nxt = ST_SO_NEXT;
        end else begin
          i_nxt = i_p1;
        end
      end
      ST_SO_NEXT: begin
        if (i_at_end) begin
          i_nxt     = '0;
          sp_nxt    = '0;
          close_nxt = 1'b0;
          state_nxt = ST_SC_NEXT;
        end else begin
          state_nxt = ST_SO_KEY;
        end
      end
      ST_SO_KEY: begin
        key_nxt   = ord_rdata;
        j_nxt     = i_r;
        state_nxt = ST_SO_KEYPT;
      end
      ST_SO_KEYPT: state_nxt = ST_SO_CHK;
      ST_SO_CHK: state_nxt = (j_r == '0) ? ST_SO_PUT : ST_SO_PREV;
      ST_SO_PREV: begin
        prev_nxt  = ord_rdata;
        state_nxt = ST_SO_PREVPT;
      end
      ST_SO_PREVPT: state_nxt = ST_SO_GO;
      ST_SO_GO: state_nxt = ST_SO_WAIT;
      ST_SO_WAIT: begin
        if (sts.ar_done) begin
          if (key_first) begin
            j_nxt     = j_m1;
            state_nxt = ST_SO_CHK;
          end else begin
            state_nxt = ST_SO_PUT;
          end
        end
      end
      ST_SO_PUT: begin
        i_nxt     = i_p1;
        state_nxt = ST_SO_NEXT;
      end
      ST_SC_NEXT: state_nxt = i_at_end ? ST_CL_RD : ST_SC_T;
      ST_SC_T: begin
        t_nxt     = ord_rdata;
        state_nxt = ST_SC_TPT;
      end
      ST_SC_TPT: state_nxt = ST_SC_CHK;
      ST_SC_CHK: begin
        if (pop_limit_ok) begin
          state_nxt = ST_SC_R2;
        end else begin
          state_nxt = close_r ? ST_DU_RD : ST_SC_PUSH;
        end
      end
      ST_SC_R2: state_nxt = ST_SC_R1;
      ST_SC_R1: state_nxt = ST_SC_R0;
      ST_SC_R0: state_nxt = ST_SC_GO;
      ST_SC_GO: state_nxt = ST_SC_WAIT;
      ST_SC_WAIT: begin
        if (sts.ar_done) begin
          if (!sts.cross_pos) begin
            sp_nxt    = sp_m1;
            state_nxt = ST_SC_CHK;
          end else begin
            state_nxt = close_r ? ST_DU_RD : ST_SC_PUSH;
          end
        end
      end
      ST_SC_PUSH: begin
        sp_nxt    = sp_r + CW'(1);
        i_nxt     = i_p1;
        state_nxt = ST_SC_NEXT;
      end
      ST_CL_RD: begin
        close_nxt = 1'b1;
        state_nxt = ST_CL_PT;
      end
      ST_CL_PT: state_nxt = ST_CL_LD;
      ST_CL_LD: state_nxt = ST_SC_CHK;
      ST_DU_RD: begin
        i_nxt     = '0;
        state_nxt = (sp_r == CW'(2)) ? ST_DU_PT : ST_EM_RD;
      end
      ST_DU_PT: state_nxt = ST_DU_CMP;
      ST_DU_CMP: begin
        if (sts.same_c) begin
          sp_nxt = CW'(1);
        end
        state_nxt = ST_EM_RD;
      end
      ST_EM_RD: state_nxt = ST_EM_PT;
      ST_EM_PT: state_nxt = ST_EM_OUT;
      ST_EM_OUT: begin
        if (sts.out_free) begin
          if (i_p1 == sp_r) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            i_nxt     = i_p1;
            state_nxt = ST_EM_RD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Commands and addresses.
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    pt_addr   = '0;
    ord_addr  = '0;
    ord_wdata = '0;
    stk_addr  = '0;
    stk_wdata = t_r;
    unique case (state_r)
      ST_LOAD: begin
        in_tready  = 1'b1;
        cmd.pt_we  = in_acc && has_room;
        pt_addr    = cnt_r[IW-1:0];
      end
      ST_PV_RD: begin
        cmd.pt_re = 1'b1;
      end
      ST_PV_FIRST: begin
        cmd.ld_a  = 1'b1;
        cmd.pt_re = 1'b1;
        pt_addr   = IW'(1);
      end
      ST_PV_SCAN: begin
        cmd.ld_a  = sts.piv_less;
        cmd.pt_re = !i_at_last;
        pt_addr   = i_p1[IW-1:0];
      end
      ST_SI_FILL: begin
        cmd.ord_we = 1'b1;
        ord_addr   = i_r[IW-1:0];
        ord_wdata  = i_r[IW-1:0];
      end
      ST_SO_NEXT: begin
        cmd.ord_re = !i_at_end;
        ord_addr   = i_r[IW-1:0];
      end
      ST_SO_KEY: begin
        cmd.pt_re = 1'b1;
        pt_addr   = ord_rdata;
      end
      ST_SO_KEYPT: cmd.ld_b = 1'b1;
      ST_SO_CHK: begin
        cmd.ord_re = j_r != '0;
        ord_addr   = j_m1[IW-1:0];
      end
      ST_SO_PREV: begin
        cmd.pt_re = 1'b1;
        pt_addr   = ord_rdata;
      end
      ST_SO_PREVPT: cmd.ld_c = 1'b1;
      ST_SO_GO: cmd.ar_go = 1'b1;
      ST_SO_WAIT: begin
        cmd.ord_we = sts.ar_done && key_first;
        ord_addr   = j_r[IW-1:0];
        ord_wdata  = prev_r;
      end
      ST_SO_PUT: begin
        cmd.ord_we = 1'b1;
        ord_addr   = j_r[IW-1:0];
        ord_wdata  = key_r;
      end
      ST_SC_NEXT: begin
        cmd.ord_re = !i_at_end;
        ord_addr   = i_r[IW-1:0];
      end
      ST_SC_T: begin
        cmd.pt_re = 1'b1;
        pt_addr   = ord_rdata;
      end
      ST_SC_TPT: cmd.ld_c = 1'b1;
      ST_SC_CHK: begin
        cmd.stk_re = pop_limit_ok;
        stk_addr   = sp_m2[IW-1:0];
      end
      ST_SC_R2: begin
        cmd.pt_re  = 1'b1;
        pt_addr    = stk_rdata;
        cmd.stk_re = 1'b1;
        stk_addr   = sp_m1[IW-1:0];
      end
      ST_SC_R1: begin
        cmd.ld_a  = 1'b1;
        cmd.pt_re = 1'b1;
        pt_addr   = stk_rdata;
      end
      ST_SC_R0: cmd.ld_b = 1'b1;
      ST_SC_GO: cmd.ar_go = 1'b1;
      ST_SC_WAIT: ;
      ST_SC_PUSH: begin
        cmd.stk_we = 1'b1;
        stk_addr   = sp_r[IW-1:0];
      end
      ST_CL_RD: cmd.stk_re = 1'b1;
      ST_CL_PT: begin
        cmd.pt_re = 1'b1;
        pt_addr   = stk_rdata;
      end
      ST_CL_LD: cmd.ld_c = 1'b1;
      ST_DU_RD: begin
        cmd.stk_re = 1'b1;
        stk_addr   = IW'(1);
      end
      ST_DU_PT: begin
        cmd.pt_re = 1'b1;
        pt_addr   = stk_rdata;
      end
      ST_DU_CMP: ;
      ST_EM_RD: begin
        cmd.stk_re = 1'b1;
        stk_addr   = i_r[IW-1:0];
      end
      ST_EM_PT: begin
        cmd.pt_re = 1'b1;
        pt_addr   = stk_rdata;
      end
      ST_EM_OUT: begin
        cmd.out_ld   = sts.out_free;
        cmd.out_last = i_p1 == sp_r;
        cmd.out_ovf  = drop_r;
      end
      default: ;
    endcase
  end

  assign hull_size = HULL_SIZE_BITS'(sp_r);

endmodule

[rtl/core/convex_hull_graham_scan_core.sv]
// Convex hull core: points stream in one per transfer, with tlast on the final point of a
// set. Up to MAX_POINTS points are held; further points are dropped and the set is flagged
// in out_tuser. After the last point the core finds the pivot, insertion-sorts the points
// around it and runs a Graham scan, then emits the hull vertices counter-clockwise from the
// pivot, tlast on the final one; collinear and duplicate points are left out. Loading takes
// one cycle per point. Processing a set of n points runs the pivot search and the order
// fill, the sort (up to n*n/2 compares) and the scan (under 2n compares), then emits the
// vertices; its pace is set by the single read port of the point memory and the cross
// product pipeline, which both the sort and the scan share. No point is taken while a set
// is being processed.
module convex_hull_graham_scan_core #(
  parameter int MAX_POINTS = chgs_pkg::DEF_MAX_POINTS,
  parameter int COORD_BITS = chgs_pkg::DEF_COORD_BITS,
  parameter int ITW        = ((2 * COORD_BITS + 7) / 8) * 8,
  parameter int OTW        = ((2 * COORD_BITS + chgs_pkg::HULL_SIZE_BITS + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [ITW-1:0] in_tdata,    // point_x, point_y
  input  logic           in_tlast,    // last_point
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [OTW-1:0] out_tdata,   // hull_x, hull_y, hull_size
  output logic           out_tlast,   // hull_last
  output logic           out_tuser    // overflowed
);
  import chgs_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);

  cmd_t cmd;
  sts_t sts;
  logic [IW-1:0] pt_addr, ord_addr, ord_wdata, ord_rdata, stk_addr, stk_wdata, stk_rdata;
  logic [HULL_SIZE_BITS-1:0] hull_size;
  logic signed [COORD_BITS-1:0] wr_x, wr_y;

  assign wr_x = in_tdata[COORD_BITS-1:0];
  assign wr_y = in_tdata[2*COORD_BITS-1:COORD_BITS];

  chgs_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tlast  (in_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .pt_addr   (pt_addr),
    .ord_addr  (ord_addr),
    .ord_wdata (ord_wdata),
    .ord_rdata (ord_rdata),
    .stk_addr  (stk_addr),
    .stk_wdata (stk_wdata),
    .stk_rdata (stk_rdata),
    .hull_size (hull_size)
  );

  chgs_dpath #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS),
    .OTW       (OTW)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .pt_addr    (pt_addr),
    .wr_x       (wr_x),
    .wr_y       (wr_y),
    .ord_addr   (ord_addr),
    .ord_wdata  (ord_wdata),
    .ord_rdata  (ord_rdata),
    .stk_addr   (stk_addr),
    .stk_wdata  (stk_wdata),
    .stk_rdata  (stk_rdata),
    .hull_size  (hull_size),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

[rtl/core/chgs_checker.sv]
// Port-level checker for the convex hull core, with its bind statement.
`include "convex_hull_graham_scan_core_macros.svh"

module chgs_checker #(
  parameter int COORD_BITS = chgs_pkg::DEF_COORD_BITS,
  parameter int OTW        = ((2 * COORD_BITS + chgs_pkg::HULL_SIZE_BITS + 7) / 8) * 8
) (
  input logic           clk,
  input logic           rst_n,
  input logic           in_tvalid,
  input logic           in_tready,
  input logic           in_tlast,
  input logic           out_tvalid,
  input logic           out_tready,
  input logic [OTW-1:0] out_tdata,
  input logic           out_tlast,
  input logic           out_tuser
);
  import chgs_pkg::*;

  localparam int SZ_LO = 2 * COORD_BITS;
  localparam int SZ_HI = SZ_LO + HULL_SIZE_BITS - 1;

  // A stalled result keeps its contents.
  `CHGS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled result changed")

  // Closing a set starts processing, so no point is taken in the next cycle.
  `CHGS_ASSERT_NXT(a_busy_after_last, in_tvalid && in_tready && in_tlast, !in_tready, "point taken right after the last one")

  // While a vertex other than the final one is on offer, no new point is taken.
  `CHGS_ASSERT_IMP(a_no_load_mid_hull, out_tvalid && !out_tlast, !in_tready, "point taken during hull emission")

  // Every hull holds at least one vertex.
  `CHGS_ASSERT_IMP(a_size_nonzero, out_tvalid, out_tdata[SZ_HI:SZ_LO] != '0, "hull size of zero")

endmodule

bind convex_hull_graham_scan_core chgs_checker #(
  .COORD_BITS(COORD_BITS),
  .OTW       (OTW)
) u_chgs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

[verif/tb_top.sv]
// Self-checking testbench for the convex hull core: point sets in, hull vertices checked.
`timescale 1ns / 1ps

module tb_top;

  localparam int NPTS = chgs_pkg::DEF_MAX_POINTS;
  localparam int CB   = chgs_pkg::DEF_COORD_BITS;
  localparam int ITW  = ((2 * CB + 7) / 8) * 8;
  localparam int OTW  = ((2 * CB + chgs_pkg::HULL_SIZE_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic                 last;
  } point_t;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic                 last;
    logic [6:0]           size;
    logic                 ovf;
  } vertex_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_tvalid = 1'b0;
  logic           in_tready;
  logic [ITW-1:0] in_tdata = '0;
  logic           in_tlast = 1'b0;
  logic           out_tvalid;
  logic           out_tready = 1'b0;
  logic [OTW-1:0] out_tdata;
  logic           out_tlast;
  logic           out_tuser;

  convex_hull_graham_scan_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_t  pending_points[$];
  vertex_t expected_hull[$];
  int      error_count = 0;

  // Predictor state: the points of the set being loaded.
  longint  set_x[NPTS];
  longint  set_y[NPTS];
  int      set_count = 0;
  bit      set_dropped = 1'b0;

  function automatic longint cross3(int a, int b, int c);
    longint bx, by, cx, cy;
    bx = set_x[b] - set_x[a];
    by = set_y[b] - set_y[a];
    cx = set_x[c] - set_x[a];
    cy = set_y[c] - set_y[a];
    return bx * cy - by * cx;
  endfunction

  function automatic bit sorts_ahead(int piv, int a, int b);
    longint cr, da, db;
    cr = cross3(piv, a, b);
    if (cr != 0) return cr > 0;
    da = (set_x[a] - set_x[piv]) ** 2 + (set_y[a] - set_y[piv]) ** 2;
    db = (set_x[b] - set_x[piv]) ** 2 + (set_y[b] - set_y[piv]) ** 2;
    return da < db;
  endfunction

  // Absorbs one accepted point; on the closing point computes the hull vertices.
  task automatic predict_hull(point_t p);
    int order[NPTS];
    int stk[NPTS];
    int piv, key, j, top;
    vertex_t v;
    if (set_count < NPTS) begin
      set_x[set_count] = p.x;
      set_y[set_count] = p.y;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!p.last) return;
    piv = 0;
    for (int i = 1; i < set_count; i++)
      if (set_x[i] < set_x[piv] || (set_x[i] == set_x[piv] && set_y[i] < set_y[piv]))
        piv = i;
    for (int i = 0; i < set_count; i++) order[i] = i;
    for (int i = 1; i < set_count; i++) begin
      key = order[i];
      j = i;
      while (j > 0 && sorts_ahead(piv, key, order[j-1])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = key;
    end
    top = 0;
    for (int i = 0; i < set_count; i++) begin
      while (top > 1 && cross3(stk[top-2], stk[top-1], order[i]) <= 0) top--;
      stk[top++] = order[i];
    end
    while (top > 2 && cross3(stk[top-2], stk[top-1], stk[0]) <= 0) top--;
    if (top == 2 && set_x[stk[0]] == set_x[stk[1]] && set_y[stk[0]] == set_y[stk[1]])
      top = 1;
    for (int k = 0; k < top; k++) begin
      v.x = CB'(set_x[stk[k]]);
      v.y = CB'(set_y[stk[k]]);
      v.last = (k + 1 == top);
      v.size = 7'(top);
      v.ovf = set_dropped;
      expected_hull = {expected_hull, v};
    end
    set_count = 0;
    set_dropped = 1'b0;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Driver: bursts with gaps, and a hold-off between sets when a pause is requested.
  int  burst_left = 0;
  int  gap_left = 0;
  bit  drain_hold = 1'b0;
  always @(posedge clk) begin
    point_t p;
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_hull({in_tdata[CB-1:0], in_tdata[2*CB-1:CB],
                                                in_tlast});
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_points.size() == 0 || (drain_hold && set_count == 0)) begin
          in_tvalid <= 1'b0;
        end else begin
          p = pending_points.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {p.y, p.x};
          in_tlast <= p.last;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Monitor with its own stall pattern.
  int stall_phase = 0;
  always @(posedge clk) begin
    vertex_t w;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_hull.size() == 0) begin
          report_mismatch("unexpected vertex", out_tdata[CB-1:0], 0);
        end else begin
          w = expected_hull.pop_front();
          if ($signed(out_tdata[CB-1:0]) != w.x)
            report_mismatch("hull_x", $signed(out_tdata[CB-1:0]), w.x);
          if ($signed(out_tdata[2*CB-1:CB]) != w.y)
            report_mismatch("hull_y", $signed(out_tdata[2*CB-1:CB]), w.y);
          if (out_tdata[2*CB+6:2*CB] != w.size)
            report_mismatch("hull_size", out_tdata[2*CB+6:2*CB], w.size);
          if (out_tlast != w.last) report_mismatch("hull_last", out_tlast, w.last);
          if (out_tuser != w.ovf) report_mismatch("overflowed", out_tuser, w.ovf);
        end
      end
      stall_phase = (stall_phase + 1) % 64;
      if (stall_phase < 24) out_tready <= 1'b1;
      else if (stall_phase < 40) out_tready <= ($urandom_range(0, 3) != 0);
      else out_tready <= ($urandom_range(0, 2) == 0);
    end
  end

  function automatic logic [CB-1:0] rnd_coord(int span);
    if (span == 0) return CB'($urandom);
    return CB'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic add_point(int x, int y, bit last);
    point_t p;
    p.x = CB'(x);
    p.y = CB'(y);
    p.last = last;
    pending_points = {pending_points, p};
  endtask

  initial begin
    int n, span, count;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: single point, duplicates, collinear line, extremes, square with edge points.
    add_point(5, -7, 1'b1);
    add_point(3, 3, 1'b0); add_point(3, 3, 1'b1);
    add_point(0, 0, 1'b0); add_point(2, 2, 1'b0); add_point(1, 1, 1'b0);
    add_point(3, 3, 1'b1);
    add_point(-32768, -32768, 1'b0); add_point(32767, -32768, 1'b0);
    add_point(32767, 32767, 1'b0); add_point(-32768, 32767, 1'b0);
    add_point(0, 0, 1'b1);
    add_point(0, 0, 1'b0); add_point(4, 0, 1'b0); add_point(4, 4, 1'b0);
    add_point(0, 4, 1'b0); add_point(2, 0, 1'b0); add_point(0, 2, 1'b0);
    add_point(2, 4, 1'b0); add_point(4, 2, 1'b0); add_point(-1, 2, 1'b1);

    // Random sets; the first overfills the store so some points are dropped.
    count = 0;
    for (int s = 0; count < 360; s++) begin
      if (s == 0) n = NPTS + 5;
      else if (s % 9 == 0) n = $urandom_range(40, NPTS);
      else n = $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0: span = 0;
        1: span = 3;
        2: span = 50;
        default: span = 2000;
      endcase
      for (int i = 0; i < n; i++) add_point(rnd_coord(span), rnd_coord(span), i == n - 1);
      count += n;
    end

    // Pause mid-run, at the end of a set, until every hull vertex so far has come back.
    wait (pending_points.size() < 150);
    drain_hold = 1'b1;
    @(posedge clk);
    while (in_tvalid || expected_hull.size() != 0 || set_count != 0) @(posedge clk);
    drain_hold = 1'b0;

    while (pending_points.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_hull.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #80ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[convex_hull_graham_scan_core.f]
+incdir+rtl/core
rtl/core/chgs_pkg.sv
rtl/core/chgs_dpath.sv
rtl/core/chgs_ctrl.sv
rtl/core/convex_hull_graham_scan_core.sv
rtl/core/chgs_checker.sv
verif/tb_top.sv
